// File: design/pced_pkg.sv
// ----------------------------------------------------------------------------
// Path cluster editing package
// Shared types and constants for the path cluster editing solver.
// ----------------------------------------------------------------------------
package pced_pkg;

   // Number of path positions held in the weight memory.
   localparam int MAX_NODES  = 64;
   localparam int COST_BITS  = 40;
   localparam int SPLIT_BITS = 7;
   localparam int LEN_BITS   = 7;
   localparam int POS_BITS   = 6;
   localparam int IN_W_BITS  = 16;
   // Accumulator width: exact sums before saturation.
   localparam int ACC_BITS   = 64;

   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREFIX,
      ST_JOIN,
      ST_CAND,
      ST_WHOLE,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load_wr;    // write the request weight
      logic start;      // latch the request length
      logic prefix_init;// begin a new prefix
      logic join_step;  // add one join term
      logic cand;       // evaluate the cut candidate
      logic whole;      // evaluate whole-clique candidate
      logic emit;       // store and present the result
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic len_zero;   // compute with empty path
      logic one_node;   // current prefix has one node
      logic join_done;  // join row finished
      logic cut_done;   // last cut index visited
      logic last_prefix;// current prefix is the full path
   } sts_type;

endpackage

// File: design/pced_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload beat with valid and ready handshake.
// ----------------------------------------------------------------------------
interface pced_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/pced_ctrl.sv
// ----------------------------------------------------------------------------
// Path cluster editing controller
// Sequences the prefix, cut and join loops of the solver.
// ----------------------------------------------------------------------------
module pced_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_is_compute,
   input  logic               out_busy,
   input  pced_pkg::sts_type  sts,
   output pced_pkg::cmd_type  cmd
);

   pced_pkg::state_type state_ff, state_in;
   logic acc;

   assign acc = req_valid && req_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pced_pkg::ST_IDLE: begin
            if (acc && req_is_compute) state_in = pced_pkg::ST_PREFIX;
         end
         pced_pkg::ST_PREFIX: begin
            if (sts.len_zero) state_in = pced_pkg::ST_IDLE;
            else if (sts.one_node) state_in = pced_pkg::ST_EMIT;
            else state_in = pced_pkg::ST_JOIN;
         end
         pced_pkg::ST_JOIN: begin
            if (sts.join_done) state_in = sts.cut_done ? pced_pkg::ST_WHOLE
                                                       : pced_pkg::ST_CAND;
         end
         pced_pkg::ST_CAND: state_in = pced_pkg::ST_JOIN;
         pced_pkg::ST_WHOLE: state_in = pced_pkg::ST_EMIT;
         pced_pkg::ST_EMIT: begin
            if (!out_busy) state_in = sts.last_prefix ? pced_pkg::ST_IDLE
                                                      : pced_pkg::ST_PREFIX;
         end
         default: state_in = pced_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         pced_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_wr   = acc && !req_is_compute;
            cmd.start     = acc && req_is_compute;
         end
         pced_pkg::ST_PREFIX: begin
            cmd.prefix_init = 1'b1;
         end
         pced_pkg::ST_JOIN: cmd.join_step = 1'b1;
         pced_pkg::ST_CAND: cmd.cand = 1'b1;
         pced_pkg::ST_WHOLE: cmd.whole = 1'b1;
         pced_pkg::ST_EMIT: cmd.emit = !out_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pced_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == pced_pkg::ST_IDLE) else $error("ready outside idle");
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !out_busy) else $error("emit into full output");
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == pced_pkg::ST_PREFIX) else $error("start lost");

endmodule

// File: design/pced_dp.sv
// ----------------------------------------------------------------------------
// Path cluster editing datapath
// Weight memory, prefix tables, join and candidate arithmetic, output stage.
// ----------------------------------------------------------------------------
module pced_dp #(
   parameter int WEIGHT_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pced_pkg::cmd_type                      cmd,
   output pced_pkg::sts_type                      sts,
   input  logic [pced_pkg::POS_BITS-1:0]          in_row,
   input  logic [pced_pkg::POS_BITS-1:0]          in_col,
   input  logic signed [pced_pkg::IN_W_BITS-1:0]  in_weight,
   input  logic [pced_pkg::LEN_BITS-1:0]          in_len,
   output logic                                   out_busy,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [pced_pkg::LEN_BITS-1:0]          out_len,
   output logic signed [pced_pkg::COST_BITS-1:0]  out_cost,
   output logic signed [pced_pkg::SPLIT_BITS-1:0] out_split,
   output logic                                   out_last
);

   localparam int MAX_NODES = pced_pkg::MAX_NODES;
   localparam int IB = $clog2(MAX_NODES);
   localparam int CB = IB + 1;
   localparam int AB = pced_pkg::ACC_BITS;
   localparam logic signed [AB-1:0] HI = (64'sd1 <<< (pced_pkg::COST_BITS-1)) - 64'sd1;
   localparam logic signed [AB-1:0] LO = -HI - 64'sd1;

   // Weight memory, read data registered.
   logic signed [WEIGHT_BITS-1:0] wmem [MAX_NODES*MAX_NODES];
   logic signed [WEIGHT_BITS-1:0] wrd_ff;
   logic [2*IB-1:0] rd_addr;
   logic rd_en;
   logic pos_ok;

   assign pos_ok = (CB'(in_row) < CB'(MAX_NODES)) && (CB'(in_col) < CB'(MAX_NODES));

   // Prefix tables.
   logic signed [pced_pkg::COST_BITS-1:0] cmem [MAX_NODES];
   logic signed [pced_pkg::COST_BITS-1:0] crd_ff;

   logic [CB-1:0] len_ff, m_ff;
   logic [CB-1:0] i_ff;     // cut index i (row k=i+1 of join)
   logic [CB-1:0] j_ff;     // join column
   logic [1:0]    ph_ff;    // join phase: 0 issue, 1 wait, 2 accumulate
   logic signed [AB-1:0] clique_ff, best_ff;
   logic signed [pced_pkg::SPLIT_BITS-1:0] split_ff;
   logic have_ff;
   logic whole_ff; // true while joining row 0 for the whole clique
   logic signed [AB-1:0] wext;
   logic signed [AB-1:0] cand;
   logic signed [AB-1:0] sat;
   logic [CB-1:0] k;

   assign wext = AB'(wrd_ff);
   assign k = whole_ff ? '0 : i_ff + CB'(1);

   // Join walks columns j=k+2..m-1 then, for a cut, reads w(i,i+1) and P[i].
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (cmd.join_step && ph_ff == 2'd0) begin
         rd_en = 1'b1;
         if (j_ff < m_ff) rd_addr = {k[IB-1:0], j_ff[IB-1:0]};
         else rd_addr = {i_ff[IB-1:0], k[IB-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && pos_ok)
         wmem[{in_row[IB-1:0], in_col[IB-1:0]}] <= WEIGHT_BITS'(in_weight);
      if (rd_en) wrd_ff <= wmem[rd_addr];
      crd_ff <= cmem[i_ff[IB-1:0]];
   end

   assign cand = wext + AB'(crd_ff) + clique_ff;
   assign sat  = (best_ff > HI) ? HI : (best_ff < LO) ? LO : best_ff;

   assign sts.len_zero    = (len_ff == '0);
   assign sts.one_node    = (m_ff == CB'(1));
   assign sts.join_done   = cmd.join_step && ph_ff == 2'd2 && (j_ff >= m_ff);
   assign sts.cut_done    = whole_ff;
   assign sts.last_prefix = (m_ff == len_ff);

   // Loop control and accumulation.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         len_ff <= (in_len > pced_pkg::LEN_BITS'(MAX_NODES)) ? CB'(MAX_NODES) : CB'(in_len);
         m_ff   <= CB'(1);
      end
      if (cmd.prefix_init) begin
         clique_ff <= '0;
         best_ff   <= '0;
         split_ff  <= '1;
         have_ff   <= 1'b0;
         whole_ff  <= (m_ff < CB'(2));
         i_ff      <= m_ff - CB'(2);
         j_ff      <= m_ff + CB'(1);
         ph_ff     <= 2'd0;
      end
      if (cmd.join_step) begin
         unique case (ph_ff)
            2'd0: ph_ff <= 2'd1;
            2'd1: ph_ff <= 2'd2;
            default: begin
               ph_ff <= 2'd0;
               if (j_ff < m_ff) clique_ff <= clique_ff - wext;
               j_ff <= j_ff + CB'(1);
            end
         endcase
      end
      if (cmd.cand) begin
         if (!have_ff || cand < best_ff) begin
            best_ff  <= cand;
            split_ff <= pced_pkg::SPLIT_BITS'(i_ff);
         end
         have_ff <= 1'b1;
         if (i_ff == '0) begin
            whole_ff <= 1'b1;
            j_ff     <= CB'(2);
         end else begin
            i_ff <= i_ff - CB'(1);
            j_ff <= i_ff + CB'(2);
         end
      end
      if (cmd.whole && clique_ff < best_ff) begin
         best_ff  <= clique_ff;
         split_ff <= '1;
      end
      if (cmd.emit) begin
         cmem[m_ff[IB-1:0] - IB'(1)] <= sat[pced_pkg::COST_BITS-1:0];
         m_ff <= m_ff + CB'(1);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.emit) begin
         out_len   <= pced_pkg::LEN_BITS'(m_ff);
         out_cost  <= sat[pced_pkg::COST_BITS-1:0];
         out_split <= split_ff;
         out_last  <= (m_ff == len_ff);
      end
   end
   assign out_busy = out_valid && !out_ready;

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> out_valid) else $error("result not presented");
   assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      cmd.cand |-> $past(sts.join_done)) else $error("candidate before join");

endmodule

// File: design/path_cluster_editing_dp.sv
// ----------------------------------------------------------------------------
// Path cluster editing solver, top level
// Prefix dynamic programme for cluster editing on a path.
// ----------------------------------------------------------------------------
// Usage: the req channel carries load and compute beats. A load beat writes a
// pair weight into the weight memory and gives no result. A compute beat of
// length L gives min(L, 64) rsp beats, one per prefix in increasing length,
// with last set on the final one.
// Operation: prefix m runs its cut loop over i = m-2 down to 0; each cut sums a
// join row and reads one weight; all weight reads go through the single
// registered weight read port.
// The block takes no new req beat until the compute is finished and its last
// result is in the output register.
// Reset clears the controller and output valid; the memories are undefined
// until written. When the receiver stalls, the result holds in the output
// register and the sequencer waits.
// ----------------------------------------------------------------------------
module path_cluster_editing_dp #(
   parameter int WEIGHT_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_req_type,
   input  logic [5:0] req_row_pos,
   input  logic [5:0] req_col_pos,
   input  logic signed [15:0] req_pair_weight,
   input  logic [6:0] req_path_length,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [6:0] rsp_prefix_length,
   output logic signed [39:0] rsp_best_cost,
   output logic signed [6:0] rsp_split_index,
   output logic rsp_last
);

   pced_pkg::cmd_type cmd;
   pced_pkg::sts_type sts;
   logic out_busy;

   pced_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .req_is_compute(req_req_type == pced_pkg::REQ_COMPUTE),
      .out_busy, .sts, .cmd
   );

   pced_dp #(.WEIGHT_BITS(WEIGHT_BITS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .in_row(req_row_pos), .in_col(req_col_pos),
      .in_weight(req_pair_weight), .in_len(req_path_length),
      .out_busy, .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_len(rsp_prefix_length), .out_cost(rsp_best_cost),
      .out_split(rsp_split_index), .out_last(rsp_last)
   );

endmodule

// File: verif/tb_path_cluster_editing_dp.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Path cluster editing solver testbench
// Loads pair weights and requests prefix sweeps over the request channel. A
// directed table covers weight extremes and the special
// lengths. A random phase follows, with short paths mostly and a longer path
// swept twice at the end. Every result beat is compared against its expected
// beat, from a local prefix cost predictor or from the directed table.
// ----------------------------------------------------------------------------
module tb_path_cluster_editing_dp;

   localparam int NODES = pced_pkg::MAX_NODES;

   typedef struct packed {
      logic               req_type;
      logic [5:0]         row_pos;
      logic [5:0]         col_pos;
      logic signed [15:0] pair_weight;
      logic [6:0]         path_length;
   } req_beat_type;

   typedef struct packed {
      logic [6:0]         prefix_length;
      logic signed [39:0] best_cost;
      logic signed [6:0]  split_index;
      logic               last;
   } rsp_beat_type;

   // One directed row; typed rows carry the cost and split of prefix two.
   typedef struct {
      logic               req_type;
      logic [5:0]         row_pos;
      logic [5:0]         col_pos;
      logic signed [15:0] pair_weight;
      logic [6:0]         path_length;
      bit                 typed;
      longint             cost_two;
      int                 split_two;
   } table_row_type;

   logic clock;
   logic reset;

   pced_if #(.payload_type(req_beat_type)) req_ch ();
   pced_if #(.payload_type(rsp_beat_type)) rsp_ch ();

   path_cluster_editing_dp i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_req_type      (req_ch.data.req_type),
      .req_row_pos       (req_ch.data.row_pos),
      .req_col_pos       (req_ch.data.col_pos),
      .req_pair_weight   (req_ch.data.pair_weight),
      .req_path_length   (req_ch.data.path_length),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_prefix_length (rsp_ch.data.prefix_length),
      .rsp_best_cost     (rsp_ch.data.best_cost),
      .rsp_split_index   (rsp_ch.data.split_index),
      .rsp_last          (rsp_ch.data.last)
   );

   // Predictor state.
   longint       pair_wt [NODES][NODES];
   bit           pair_set [NODES][NODES];
   longint       prefix_cost [NODES];
   rsp_beat_type prefix_results[$];
   int           mismatches;
   bit           burst;

   // Clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Cost of joining node k to nodes k+2..m-1 as added non-edges.
   function automatic longint join_row(int k, int m);
      longint c;
      c = 0;
      for (int j = k + 2; j < m; j++) c -= pair_wt[k][j];
      return c;
   endfunction

   // Sweep every prefix of a path and, if asked, queue the expected result beats.
   function automatic void sweep_prefixes(int req_len, bit queue_them);
      longint       best;
      longint       clique;
      longint       cand;
      int           split;
      int           len;
      bit           have;
      rsp_beat_type r;
      len = (req_len > NODES) ? NODES : req_len;
      for (int m = 1; m <= len; m++) begin
         best  = 0;
         split = -1;
         if (m > 1) begin
            clique = 0;
            have   = 0;
            for (int i = m - 2; i >= 0; i--) begin
               clique += join_row(i + 1, m);
               cand = pair_wt[i][i + 1] + prefix_cost[i] + clique;
               if (!have || cand < best) begin
                  best  = cand;
                  split = i;
                  have  = 1;
               end
            end
            clique += join_row(0, m);
            if (clique < best) begin
               best  = clique;
               split = -1;
            end
         end
         if (best > 64'sd549755813887) best = 64'sd549755813887;
         if (best < -64'sd549755813888) best = -64'sd549755813888;
         prefix_cost[m - 1] = best;
         r.prefix_length = m[6:0];
         r.best_cost     = best[39:0];
         r.split_index   = split[6:0];
         r.last          = (m == len);
         if (queue_them) prefix_results.push_back(r);
      end
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (burst || p < 65) return 0;
      if (p < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Drive one beat after an optional gap and wait for its acceptance.
   task automatic send_beat(req_beat_type b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= b;
      do @(posedge clock); while (!req_ch.ready);
      if (b.req_type == pced_pkg::REQ_LOAD) begin
         pair_wt[b.row_pos][b.col_pos]  = longint'(b.pair_weight);
         pair_set[b.row_pos][b.col_pos] = 1'b1;
      end
   endtask

   task automatic send_load(int r, int c, logic signed [15:0] w);
      req_beat_type b;
      b = '0;
      b.req_type    = pced_pkg::REQ_LOAD;
      b.row_pos     = r[5:0];
      b.col_pos     = c[5:0];
      b.pair_weight = w;
      send_beat(b);
   endtask

   function automatic logic signed [15:0] rand_weight();
      int p;
      p = $urandom_range(9);
      if (p == 0) return 16'sh7FFF;
      if (p == 1) return 16'sh8000;
      if (p < 5) return 16'($urandom_range(40) - 20);
      return 16'($urandom());
   endfunction

   // Write every pair that a sweep of this length will read and that is not yet set.
   task automatic fill_pairs(int len);
      int n;
      n = (len > NODES) ? NODES : len;
      for (int b = 1; b < n; b++)
         for (int a = 0; a < b; a++)
            if (!pair_set[a][b]) send_load(a, b, rand_weight());
   endtask

   task automatic send_compute(int len);
      req_beat_type b;
      b = '0;
      b.req_type    = pced_pkg::REQ_COMPUTE;
      b.path_length = len[6:0];
      send_beat(b);
      sweep_prefixes(len, 1'b1);
   endtask

   // Receiver stalls.
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!burst && $urandom_range(99) < 25)
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                   : $urandom_range(3, 1);
      end
   end

   // Result checking against the oldest expectation.
   always @(posedge clock) begin
      rsp_beat_type want;
      rsp_beat_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (prefix_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: len %0d cost %0d split %0d last %0d",
                        got.prefix_length, got.best_cost, got.split_index, got.last);
         end else begin
            want = prefix_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: len %0d/%0d cost %0d/%0d split %0d/%0d last %0d/%0d",
                           want.prefix_length, got.prefix_length,
                           want.best_cost, got.best_cost,
                           want.split_index, got.split_index, want.last, got.last);
            end
         end
      end
   end

   table_row_type dir_rows[] = '{
      '{pced_pkg::REQ_COMPUTE, 0, 0, 0, 1, 1, 0, 0},
      '{pced_pkg::REQ_COMPUTE, 0, 0, 0, 0, 0, 0, 0},
      '{pced_pkg::REQ_LOAD, 0, 1, 16'sh7FFF, 0, 0, 0, 0},
      '{pced_pkg::REQ_COMPUTE, 0, 0, 0, 2, 1, 0, -1},
      '{pced_pkg::REQ_LOAD, 0, 1, 16'sh8000, 0, 0, 0, 0},
      '{pced_pkg::REQ_COMPUTE, 0, 0, 0, 2, 1, -32768, 0},
      '{pced_pkg::REQ_LOAD, 0, 2, 16'sh8000, 0, 0, 0, 0},
      '{pced_pkg::REQ_LOAD, 1, 2, 16'sh7FFF, 0, 0, 0, 0},
      '{pced_pkg::REQ_COMPUTE, 0, 0, 0, 3, 0, 0, 0},
      '{pced_pkg::REQ_LOAD, 0, 2, 16'sh7FFF, 0, 0, 0, 0},
      '{pced_pkg::REQ_LOAD, 1, 2, 16'sh8000, 0, 0, 0, 0},
      '{pced_pkg::REQ_COMPUTE, 0, 0, 0, 3, 0, 0, 0},
      '{pced_pkg::REQ_LOAD, 62, 63, -16'sd1, 0, 0, 0, 0},
      '{pced_pkg::REQ_LOAD, 63, 0, 16'sd12345, 0, 0, 0, 0},
      '{pced_pkg::REQ_LOAD, 5, 5, -16'sd1, 0, 0, 0, 0},
      '{pced_pkg::REQ_LOAD, 42, 21, 16'sh5555, 0, 0, 0, 0},
      '{pced_pkg::REQ_LOAD, 0, 1, 16'sd0, 0, 0, 0, 0},
      '{pced_pkg::REQ_COMPUTE, 0, 0, 0, 3, 0, 0, 0}
   };

   // Stimulus.
   initial begin
      req_beat_type b;
      rsp_beat_type r;
      int           items;
      int           len;
      int           a;
      int           c;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      mismatches   = 0;
      burst        = 0;
      foreach (pair_set[i, j]) begin
         pair_set[i][j] = 0;
         pair_wt[i][j]  = 0;
      end
      foreach (prefix_cost[i]) prefix_cost[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      foreach (dir_rows[k]) begin
         b.req_type    = dir_rows[k].req_type;
         b.row_pos     = dir_rows[k].row_pos;
         b.col_pos     = dir_rows[k].col_pos;
         b.pair_weight = dir_rows[k].pair_weight;
         b.path_length = dir_rows[k].path_length;
         send_beat(b);
         if (b.req_type == pced_pkg::REQ_COMPUTE) begin
            sweep_prefixes(b.path_length, !dir_rows[k].typed);
            if (dir_rows[k].typed) begin
               // A one-node prefix always costs nothing and is one cluster.
               r = '{7'd1, 40'sd0, -7'sd1, b.path_length == 1};
               prefix_results.push_back(r);
               if (b.path_length == 2) begin
                  r = '{7'd2, dir_rows[k].cost_two[39:0],
                        dir_rows[k].split_two[6:0], 1'b1};
                  prefix_results.push_back(r);
               end
            end
         end
      end

      // Random part: short paths, loads anywhere, some ignored-position noise.
      items = 0;
      while (items < 250) begin
         if (items % 60 == 0) burst = ($urandom_range(3) == 0);
         if ($urandom_range(5) == 0) begin
            len = ($urandom_range(15) == 0) ? $urandom_range(20, 11)
                                            : $urandom_range(10);
            fill_pairs(len);
            send_compute(len);
         end else begin
            a = $urandom_range(NODES - 1);
            c = $urandom_range(NODES - 1);
            if ($urandom_range(7) != 0 && a != c) begin
               if (a > c) begin
                  int t;
                  t = a;
                  a = c;
                  c = t;
               end
            end
            send_load(a, c, rand_weight());
         end
         items++;
      end

      // A longer path, swept again after one of its weights changes.
      burst = 0;
      fill_pairs(24);
      send_compute(24);
      send_load(10, 11, rand_weight());
      send_compute(24);
      req_ch.valid <= 1'b0;

      while (prefix_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog.
   initial begin
      #200_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
